>>> design/pgr_pkg.sv
package pgr_pkg;

	localparam int CoordW = 12;
	localparam int MsW = 16;
	localparam int RadiusW = 10;
	localparam int RadiusSqW = 2 * RadiusW;
	localparam int FingerW = 4;
	localparam int CfgAddrW = 2;
	localparam int CfgDataW = 16;
	localparam int MaxBeats = 2;
	localparam int FifoDepth = 4;
	localparam int FifoPtrW = $clog2(FifoDepth);
	localparam int FifoCntW = $clog2(FifoDepth + 1);

	localparam logic [FingerW-1:0] FingerMax = '1;
	localparam logic [FingerW-1:0] MultiFingers = FingerW'(2);
	localparam logic [MsW-1:0] MsMax = '1;

	localparam logic [RadiusSqW-1:0] RadiusSqReset = RadiusSqW'(400);
	localparam logic [MsW-1:0] DoubleMsReset = MsW'(300);
	localparam logic [MsW-1:0] LongMsReset = MsW'(500);

	typedef enum logic [2:0] {
		REQ_FINGER_DOWN = 3'd0,
		REQ_FINGER_UP = 3'd1,
		REQ_BUTTON_DOWN = 3'd2,
		REQ_MOTION = 3'd3,
		REQ_BUTTON_UP = 3'd4,
		REQ_TICK = 3'd5
	} req_kind_t;

	typedef enum logic [2:0] {
		GST_CLICK = 3'd0,
		GST_DOUBLE = 3'd1,
		GST_LONG_BEGIN = 3'd2,
		GST_LONG_MOTION = 3'd3,
		GST_LONG_END = 3'd4,
		GST_DRAG_BEGIN = 3'd5,
		GST_DRAG_MOTION = 3'd6,
		GST_DRAG_END = 3'd7
	} gst_kind_t;

	typedef enum logic [CfgAddrW-1:0] {
		CFG_CLICK_RADIUS = 2'd0,
		CFG_DOUBLE_CLICK_MS = 2'd1,
		CFG_LONG_CLICK_MS = 2'd2
	} cfg_addr_t;

	// x in the low half
	typedef struct packed {
		logic [CoordW-1:0] y;
		logic [CoordW-1:0] x;
	} pos_t;

	typedef struct packed {
		req_kind_t kind;
		pos_t pos;
		logic primary;
	} req_t;

	typedef struct packed {
		gst_kind_t kind;
		pos_t pos;
		logic last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t [MaxBeats-1:0] beat;
	} result_set_t;

	typedef struct packed {
		logic [RadiusSqW-1:0] radius_sq;
		logic [MsW-1:0] double_ms;
		logic [MsW-1:0] long_ms;
	} cfg_t;

endpackage

>>> design/pointer_gesture_recognizer_top.sv
// Pointer gesture recognizer: takes one pointer beat (finger down/up, button down/up, motion,
// millisecond tick) per clock and turns it into click, double click, long-press and drag
// gestures. An accepted beat is held in the input register, where the state update and the
// closeness test (two 12x12 squares and a compare) happen; its gestures go into a four-entry
// result queue as it leaves. Sustained rate is one input beat per cycle; input stalls only
// while the queue holds more than two gestures. A primary button release can cause two
// gestures, which leave on two output beats, so a long run of such releases is paced by the
// output side at one gesture per cycle. Write registers via cfg_we/cfg_addr/cfg_wdata only
// while idle (not enforced by the block); the click radius is squared when it is written.
module pointer_gesture_recognizer_top import pgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CfgAddrW-1:0] cfg_addr,
	input logic [CfgDataW-1:0] cfg_wdata,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [23:0] s_axis_tdata,   // pos_x[11:0], pos_y[23:12]
	input logic [3:0] s_axis_tuser,    // req_type[2:0], is_primary[3]
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [23:0] m_axis_tdata,  // gesture_x[11:0], gesture_y[23:12]
	output logic [2:0] m_axis_tuser,   // gesture_kind[2:0]
	output logic m_axis_tlast          // last_of_run
);

	cfg_t cfg_q;
	logic valid_s1;
	req_t req_s1;
	logic fire;
	logic space_ok;
	result_set_t res;
	result_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius_sq <= RadiusSqReset;
			cfg_q.double_ms <= DoubleMsReset;
			cfg_q.long_ms <= LongMsReset;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_CLICK_RADIUS: cfg_q.radius_sq <= RadiusSqW'(cfg_wdata[RadiusW-1:0]) *
					RadiusSqW'(cfg_wdata[RadiusW-1:0]);
				CFG_DOUBLE_CLICK_MS: cfg_q.double_ms <= cfg_wdata[MsW-1:0];
				CFG_LONG_CLICK_MS: cfg_q.long_ms <= cfg_wdata[MsW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign fire = valid_s1 && space_ok;
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.kind <= req_kind_t'(s_axis_tuser[2:0]);
			req_s1.pos.x <= s_axis_tdata[11:0];
			req_s1.pos.y <= s_axis_tdata[23:12];
			req_s1.primary <= s_axis_tuser[3];
		end
	end

	pgr_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.req(req_s1),
		.cfg(cfg_q),
		.res(res)
	);

	pgr_res_fifo u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.res(res),
		.space_ok(space_ok),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.head(head)
	);

	assign m_axis_tdata = {head.pos.y, head.pos.x};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.last;

endmodule

>>> design/pgr_core.sv
module pgr_core import pgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input req_t req,
	input cfg_t cfg,
	output result_set_t res
);

	logic [FingerW-1:0] finger_count_q, finger_count_d;
	logic multi_touch_block_q, multi_touch_block_d;
	logic pointer_down_q, pointer_down_d;
	logic in_long_press_q, in_long_press_d;
	logic in_drag_q, in_drag_d;
	logic press_valid_q, press_valid_d;
	pos_t press_pos_q, press_pos_d;
	logic pending_valid_q, pending_valid_d;
	pos_t pending_pos_q, pending_pos_d;
	logic double_armed_q, double_armed_d;
	logic [MsW-1:0] ms_since_press_q, ms_since_press_d;
	pos_t cursor_pos_q, cursor_pos_d;

	// shared closeness unit: button down: new press vs pending click; else press vs item
	pos_t near_a, near_b;
	logic near_en, near_hit;
	logic [CoordW-1:0] dx, dy;
	logic [2*CoordW-1:0] dx_sq, dy_sq;
	logic [2*CoordW:0] dist_sq;

	always_comb begin
		if (req.kind == REQ_BUTTON_DOWN) begin
			near_a = req.pos;
			near_b = pending_pos_q;
			near_en = 1'b1;
		end else begin
			near_a = press_pos_q;
			near_b = req.pos;
			near_en = press_valid_q;
		end
		dx = (near_a.x >= near_b.x) ? near_a.x - near_b.x : near_b.x - near_a.x;
		dy = (near_a.y >= near_b.y) ? near_a.y - near_b.y : near_b.y - near_a.y;
		dx_sq = (2*CoordW)'(dx) * (2*CoordW)'(dx);
		dy_sq = (2*CoordW)'(dy) * (2*CoordW)'(dy);
		dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
		near_hit = near_en && (dist_sq < (2*CoordW+1)'(cfg.radius_sq));
	end

	logic [MsW-1:0] ms_inc;
	logic click_hit;
	result_t first_beat, second_beat;
	logic first_v, second_v;

	always_comb begin
		finger_count_d = finger_count_q;
		multi_touch_block_d = multi_touch_block_q;
		pointer_down_d = pointer_down_q;
		in_long_press_d = in_long_press_q;
		in_drag_d = in_drag_q;
		press_valid_d = press_valid_q;
		press_pos_d = press_pos_q;
		pending_valid_d = pending_valid_q;
		pending_pos_d = pending_pos_q;
		double_armed_d = double_armed_q;
		ms_since_press_d = ms_since_press_q;
		cursor_pos_d = cursor_pos_q;
		first_v = 1'b0;
		second_v = 1'b0;
		first_beat = '0;
		second_beat = '0;
		ms_inc = (ms_since_press_q == MsMax) ? ms_since_press_q : ms_since_press_q + 1'b1;
		click_hit = near_hit && (ms_since_press_q < cfg.long_ms);

		unique case (req.kind)
			REQ_FINGER_DOWN: begin
				if (finger_count_q != FingerMax) finger_count_d = finger_count_q + 1'b1;
				if (finger_count_d >= MultiFingers) multi_touch_block_d = 1'b1;
			end
			REQ_FINGER_UP: begin
				if (finger_count_q != '0) finger_count_d = finger_count_q - 1'b1;
				if (finger_count_d == '0) multi_touch_block_d = 1'b0;
			end
			REQ_BUTTON_DOWN: begin
				if (req.primary) pointer_down_d = 1'b1;
				press_pos_d = req.pos;
				press_valid_d = 1'b1;
				if (pending_valid_q && ms_since_press_q < cfg.double_ms && near_hit)
					double_armed_d = 1'b1;
				ms_since_press_d = '0;
			end
			REQ_MOTION: begin
				cursor_pos_d = req.pos;
				if (pointer_down_q && finger_count_q < MultiFingers) begin
					if (in_long_press_q) begin
						first_v = 1'b1;
						first_beat = '{kind: GST_LONG_MOTION, pos: req.pos, last: 1'b0};
					end else if (!near_hit && !in_drag_q) begin
						first_v = 1'b1;
						first_beat = '{kind: GST_DRAG_BEGIN, pos: req.pos, last: 1'b0};
						in_drag_d = 1'b1;
					end else if (in_drag_q) begin
						first_v = 1'b1;
						first_beat = '{kind: GST_DRAG_MOTION, pos: req.pos, last: 1'b0};
					end
				end
			end
			REQ_BUTTON_UP: begin
				if (req.primary) begin
					pointer_down_d = 1'b0;
					if (click_hit) begin
						first_v = 1'b1;
						if (double_armed_q) begin
							first_beat = '{kind: GST_DOUBLE, pos: pending_pos_q, last: 1'b0};
							pending_valid_d = 1'b0;
						end else begin
							first_beat = '{kind: GST_CLICK, pos: press_pos_q, last: 1'b0};
							pending_pos_d = press_pos_q;
							pending_valid_d = 1'b1;
						end
					end
					if (in_long_press_q) begin
						second_v = 1'b1;
						second_beat = '{kind: GST_LONG_END, pos: req.pos, last: 1'b0};
						pending_valid_d = 1'b0;
						in_long_press_d = 1'b0;
					end else if (in_drag_q) begin
						second_v = 1'b1;
						second_beat = '{kind: GST_DRAG_END, pos: req.pos, last: 1'b0};
						in_drag_d = 1'b0;
					end
					press_valid_d = 1'b0;
				end
				double_armed_d = 1'b0;
			end
			REQ_TICK: begin
				ms_since_press_d = ms_inc;
				if (!in_long_press_q && pointer_down_q && !multi_touch_block_q &&
						ms_inc > cfg.long_ms && !in_drag_q) begin
					first_v = 1'b1;
					first_beat = '{kind: GST_LONG_BEGIN, pos: cursor_pos_q, last: 1'b0};
					in_long_press_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// pack the beats to the front and mark the final one
	always_comb begin
		res = '0;
		if (fire) begin
			priority if (first_v && second_v) begin
				res.cnt = 2'd2;
				res.beat[0] = first_beat;
				res.beat[1] = second_beat;
				res.beat[1].last = 1'b1;
			end else if (first_v) begin
				res.cnt = 2'd1;
				res.beat[0] = first_beat;
				res.beat[0].last = 1'b1;
			end else if (second_v) begin
				res.cnt = 2'd1;
				res.beat[0] = second_beat;
				res.beat[0].last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finger_count_q <= '0;
			multi_touch_block_q <= 1'b0;
			pointer_down_q <= 1'b0;
			in_long_press_q <= 1'b0;
			in_drag_q <= 1'b0;
			press_valid_q <= 1'b0;
			press_pos_q <= '0;
			pending_valid_q <= 1'b0;
			pending_pos_q <= '0;
			double_armed_q <= 1'b0;
			ms_since_press_q <= '0;
			cursor_pos_q <= '0;
		end else if (fire) begin
			finger_count_q <= finger_count_d;
			multi_touch_block_q <= multi_touch_block_d;
			pointer_down_q <= pointer_down_d;
			in_long_press_q <= in_long_press_d;
			in_drag_q <= in_drag_d;
			press_valid_q <= press_valid_d;
			press_pos_q <= press_pos_d;
			pending_valid_q <= pending_valid_d;
			pending_pos_q <= pending_pos_d;
			double_armed_q <= double_armed_d;
			ms_since_press_q <= ms_since_press_d;
			cursor_pos_q <= cursor_pos_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_long_and_drag: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_long_press_q && in_drag_q))
		else $error("long press and drag active together");

	a_multi_touch_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(finger_count_q >= MultiFingers) |-> multi_touch_block_q)
		else $error("multi-touch block clear with two or more fingers");

	a_two_beats_only_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		(res.cnt == 2'd2) |-> (fire && req.kind == REQ_BUTTON_UP && req.primary))
		else $error("two gestures from an item other than a primary release");
`endif

endmodule

>>> design/pgr_res_fifo.sv
module pgr_res_fifo import pgr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input result_set_t res,
	output logic space_ok,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output result_t head
);

	result_t entry_q [FifoDepth];
	logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FifoCntW-1:0] count_q;
	logic pop;

	assign pop = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = (count_q != '0);
	assign head = entry_q[rd_ptr_q];
	// room for the largest burst one item can cause
	assign space_ok = (count_q <= FifoCntW'(FifoDepth - MaxBeats));

	always_ff @(posedge clk) begin
		if (res.cnt != 2'd0) entry_q[wr_ptr_q] <= res.beat[0];
		if (res.cnt == 2'd2) entry_q[wr_ptr_q + 1'b1] <= res.beat[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FifoPtrW'(res.cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + FifoCntW'(res.cnt) - FifoCntW'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FifoCntW'(FifoDepth))
		else $error("result queue overflow");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(res.cnt != 2'd0) |-> space_ok)
		else $error("results pushed without room");

	a_drains_to_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && count_q == FifoCntW'(1) && res.cnt == 2'd0) |=> !m_axis_tvalid)
		else $error("queue not empty after last beat left");
`endif

endmodule

>>> sim/pointer_gesture_recognizer_top_tb.sv
module pointer_gesture_recognizer_top_tb import pgr_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ReqSpareLo = 3'd6;
	localparam logic [2:0] ReqSpareHi = 3'd7;
	localparam logic [CfgAddrW-1:0] CfgAddrSpare = 2'd3;
	localparam int QuietLimit = 2000;
	localparam int SettleCycles = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // pos_x[11:0], pos_y[23:12]
	logic [3:0] s_axis_tuser = '0;    // req_type[2:0], is_primary[3]
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // gesture_x[11:0], gesture_y[23:12]
	logic [2:0] m_axis_tuser;         // gesture_kind[2:0]
	logic m_axis_tlast;               // last_of_run

	pointer_gesture_recognizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #10 clk = ~clk;

	// register shadows
	logic [RadiusW-1:0] radius_cfg = 10'd20;
	logic [MsW-1:0] dbl_ms_cfg = DoubleMsReset;
	logic [MsW-1:0] long_ms_cfg = LongMsReset;

	// gesture tracker state
	logic [FingerW-1:0] finger_cnt = '0;
	logic multi_block = 1'b0;
	logic ptr_down = 1'b0;
	logic long_active = 1'b0;
	logic drag_active = 1'b0;
	logic press_held = 1'b0;
	pos_t press_at = '0;
	logic pend_valid = 1'b0;
	pos_t pend_at = '0;
	logic dbl_armed = 1'b0;
	logic [MsW-1:0] ms_elapsed = '0;
	pos_t cursor_at = '0;

	result_t gestures_due[$];
	int mismatches = 0;
	int reqs_sent = 0;
	int quiet_cycles = 0;
	int sink_hold = 0;
	int sink_stall = 0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pos_t rand_pos();
		return pos_t'(24'($urandom));
	endfunction

	function automatic logic any_bit();
		return 1'($urandom);
	endfunction

	function automatic pos_t jitter(pos_t at, int span);
		pos_t p;
		p.x = at.x + 12'($urandom_range(0, 2 * span) - span);
		p.y = at.y + 12'($urandom_range(0, 2 * span) - span);
		return p;
	endfunction

	function automatic bit near_press(pos_t p);
		int dx, dy, rad;
		dx = int'(press_at.x) - int'(p.x);
		dy = int'(press_at.y) - int'(p.y);
		rad = int'(radius_cfg);
		return press_held && (dx * dx + dy * dy < rad * rad);
	endfunction

	function automatic result_t gesture(gst_kind_t k, pos_t p);
		result_t r;
		r.kind = k;
		r.pos = p;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic predict_gestures(input logic [2:0] kind, input pos_t at, input logic prim);
		result_t run[$];
		result_t r;
		case (kind)
			REQ_FINGER_DOWN: begin
				if (finger_cnt < FingerMax) finger_cnt++;
				if (finger_cnt >= MultiFingers) multi_block = 1'b1;
			end
			REQ_FINGER_UP: begin
				if (finger_cnt > 0) finger_cnt--;
				if (finger_cnt == 0) multi_block = 1'b0;
			end
			REQ_BUTTON_DOWN: begin
				if (prim) ptr_down = 1'b1;
				press_at = at;
				press_held = 1'b1;
				if (pend_valid && ms_elapsed < dbl_ms_cfg && near_press(pend_at))
					dbl_armed = 1'b1;
				ms_elapsed = '0;
			end
			REQ_MOTION: begin
				cursor_at = at;
				if (ptr_down && finger_cnt < MultiFingers) begin
					if (long_active) begin
						run.push_back(gesture(GST_LONG_MOTION, at));
					end else if (!near_press(at) && !drag_active) begin
						run.push_back(gesture(GST_DRAG_BEGIN, at));
						drag_active = 1'b1;
					end else if (drag_active) begin
						run.push_back(gesture(GST_DRAG_MOTION, at));
					end
				end
			end
			REQ_BUTTON_UP: begin
				if (prim) begin
					ptr_down = 1'b0;
					if (near_press(at) && ms_elapsed < long_ms_cfg) begin
						if (dbl_armed) begin
							run.push_back(gesture(GST_DOUBLE, pend_at));
							pend_valid = 1'b0;
						end else begin
							run.push_back(gesture(GST_CLICK, press_at));
							pend_at = press_at;
							pend_valid = 1'b1;
						end
					end
					if (long_active) begin
						run.push_back(gesture(GST_LONG_END, at));
						pend_valid = 1'b0;
						long_active = 1'b0;
					end else if (drag_active) begin
						run.push_back(gesture(GST_DRAG_END, at));
						drag_active = 1'b0;
					end
					press_held = 1'b0;
				end
				dbl_armed = 1'b0;
			end
			REQ_TICK: begin
				if (ms_elapsed < MsMax) ms_elapsed++;
				// elapsed time is bumped before the long-press test
				if (!long_active && ptr_down && !multi_block && ms_elapsed > long_ms_cfg &&
						!drag_active) begin
					run.push_back(gesture(GST_LONG_BEGIN, cursor_at));
					long_active = 1'b1;
				end
			end
			default: begin
			end
		endcase
		foreach (run[i]) begin
			r = run[i];
			r.last = (i == run.size() - 1);
			gestures_due.push_back(r);
		end
	endtask

	// valid stays high across back-to-back beats
	task automatic send_req(input logic [2:0] kind, input pos_t at, input logic prim);
		int gap;
		gap = src_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= at;
		s_axis_tuser <= {prim, kind};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_gestures(kind, at, prim);
		if (kind <= REQ_TICK) reqs_sent++;
	endtask

	task automatic tick_burst(input int n);
		repeat (n) send_req(REQ_TICK, rand_pos(), any_bit());
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (gestures_due.size() != 0) @(posedge clk);
		// a beat with no gesture may still be in flight
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_CLICK_RADIUS: radius_cfg = val[RadiusW-1:0];
			CFG_DOUBLE_CLICK_MS: dbl_ms_cfg = val;
			CFG_LONG_CLICK_MS: long_ms_cfg = val;
			default: begin
			end
		endcase
	endtask

	task automatic apply_settings(input int radius, input int dbl, input int lng);
		wait_idle();
		// upper bits of the radius write are don't-care
		write_reg(CFG_CLICK_RADIUS, {6'($urandom), 10'(radius)});
		write_reg(CFG_DOUBLE_CLICK_MS, 16'(dbl));
		write_reg(CFG_LONG_CLICK_MS, 16'(lng));
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_gestures();
		send_req(ReqSpareLo, '1, 1'b1);
		send_req(ReqSpareHi, '0, 1'b0);
		send_req(REQ_BUTTON_UP, '0, 1'b1);
		send_req(REQ_BUTTON_DOWN, '0, 1'b1);
		send_req(REQ_BUTTON_UP, '0, 1'b1);
		send_req(REQ_BUTTON_DOWN, pos_t'({12'd5, 12'd5}), 1'b1);
		send_req(REQ_BUTTON_UP, pos_t'({12'd5, 12'd5}), 1'b1);
		send_req(REQ_BUTTON_DOWN, '1, 1'b0);
		send_req(REQ_BUTTON_UP, '1, 1'b0);
		send_req(REQ_BUTTON_UP, '1, 1'b1);
		send_req(REQ_BUTTON_DOWN, '1, 1'b1);
		send_req(REQ_MOTION, '1, 1'b1);
		send_req(REQ_MOTION, pos_t'({12'd4095, 12'd0}), 1'b1);
		send_req(REQ_MOTION, pos_t'({12'd1024, 12'd2048}), 1'b1);
		// double click and drag end on the same release
		send_req(REQ_BUTTON_UP, pos_t'({12'd4090, 12'd4095}), 1'b1);
		apply_settings(20, 300, 3);
		send_req(REQ_BUTTON_DOWN, pos_t'({12'd200, 12'd100}), 1'b1);
		send_req(REQ_MOTION, pos_t'({12'd200, 12'd101}), 1'b1);
		tick_burst(4);
		send_req(REQ_MOTION, pos_t'({12'd10, 12'd3000}), 1'b1);
		send_req(REQ_BUTTON_UP, pos_t'({12'd10, 12'd3000}), 1'b1);
		send_req(REQ_BUTTON_DOWN, pos_t'({12'd10, 12'd10}), 1'b1);
		send_req(REQ_MOTION, pos_t'({12'd500, 12'd500}), 1'b1);
		send_req(REQ_BUTTON_UP, pos_t'({12'd10, 12'd12}), 1'b1);
		wait_idle();
		write_reg(CfgAddrSpare, '1);
		cfg_we <= 1'b0;
	endtask

	task automatic test_finger_limits();
		repeat (2) send_req(REQ_FINGER_DOWN, rand_pos(), any_bit());
		send_req(REQ_BUTTON_DOWN, pos_t'({12'd50, 12'd50}), 1'b1);
		tick_burst(5);
		send_req(REQ_MOTION, pos_t'({12'd900, 12'd900}), 1'b1);
		// one finger left, but the block only lifts at zero
		send_req(REQ_FINGER_UP, rand_pos(), any_bit());
		tick_burst(2);
		send_req(REQ_MOTION, pos_t'({12'd900, 12'd900}), 1'b1);
		repeat (16) send_req(REQ_FINGER_DOWN, rand_pos(), any_bit());
		repeat (17) send_req(REQ_FINGER_UP, rand_pos(), any_bit());
		tick_burst(2);
		send_req(REQ_BUTTON_UP, pos_t'({12'd900, 12'd900}), 1'b1);
	endtask

	task automatic test_backpressure();
		pos_t p;
		apply_settings(20, 300, 500);
		src_idle_on = 1'b0;
		p = rand_pos();
		sink_hold = 300;
		send_req(REQ_BUTTON_DOWN, p, 1'b1);
		repeat (30) send_req(REQ_MOTION, jitter(p, 1500), 1'b1);
		send_req(REQ_BUTTON_UP, rand_pos(), 1'b1);
		wait_idle();
		src_idle_on = 1'b1;
	endtask

	task automatic run_scenario();
		pos_t p;
		int near_span, n;
		near_span = int'(radius_cfg) / 2;
		p = rand_pos();
		if (finger_cnt > 1 && $urandom_range(0, 1) == 0)
			while (finger_cnt > 0) send_req(REQ_FINGER_UP, rand_pos(), any_bit());
		case ($urandom_range(0, 9))
			0, 1: begin
				send_req(REQ_BUTTON_DOWN, p, $urandom_range(0, 7) != 0);
				tick_burst($urandom_range(0, 3));
				send_req(REQ_BUTTON_UP, jitter(p, near_span), 1'b1);
				if ($urandom_range(0, 1) == 0) begin
					tick_burst($urandom_range(0, 4));
					send_req(REQ_BUTTON_DOWN, jitter(p, near_span), 1'b1);
					send_req(REQ_BUTTON_UP, jitter(p, near_span), $urandom_range(0, 7) != 0);
				end
			end
			2, 3: begin
				send_req(REQ_BUTTON_DOWN, p, 1'b1);
				n = (long_ms_cfg < 30) ? int'(long_ms_cfg) + $urandom_range(0, 3)
					: $urandom_range(0, 8);
				repeat (n) begin
					if ($urandom_range(0, 5) == 0)
						send_req(REQ_MOTION, jitter(p, near_span), any_bit());
					send_req(REQ_TICK, rand_pos(), any_bit());
				end
				repeat ($urandom_range(0, 3)) send_req(REQ_MOTION, jitter(p, near_span), any_bit());
				send_req(REQ_BUTTON_UP, jitter(p, near_span), 1'b1);
			end
			4, 5, 6: begin
				send_req(REQ_BUTTON_DOWN, p, 1'b1);
				tick_burst($urandom_range(0, 2));
				repeat ($urandom_range(1, 8))
					send_req(REQ_MOTION, jitter(p, $urandom_range(0, 1500)), any_bit());
				send_req(REQ_BUTTON_UP,
					($urandom_range(0, 1) == 0) ? jitter(p, near_span) : rand_pos(), 1'b1);
			end
			7: begin
				repeat ($urandom_range(1, 3))
					send_req((finger_cnt > 2) ? REQ_FINGER_UP : 3'($urandom_range(0, 1)),
						rand_pos(), any_bit());
			end
			default: begin
				repeat ($urandom_range(1, 5)) send_req(3'($urandom), rand_pos(), any_bit());
			end
		endcase
	endtask

	task automatic test_random_gestures();
		int target;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: apply_settings(20, 300, 8);
				1: apply_settings(0, 0, 0);
				2: apply_settings(1023, 65535, 65535);
				default: apply_settings($urandom_range(1, 300), $urandom_range(0, 60),
					$urandom_range(0, 25));
			endcase
			src_idle_on = (phase != 3);
			sink_idle_on = (phase != 3);
			target = reqs_sent + 50;
			while (reqs_sent < target) run_scenario();
		end
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else if (sink_stall > 0) begin
			sink_stall--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (sink_idle_on && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = gst_kind_t'(m_axis_tuser);
			got.pos = m_axis_tdata;
			got.last = m_axis_tlast;
			if (gestures_due.size() == 0) begin
				$display("%0t: unexpected beat, actual kind %0d at (%0d,%0d) last %0d", $time,
					got.kind, got.pos.x, got.pos.y, got.last);
				mismatches++;
			end else begin
				want = gestures_due.pop_front();
				if (got.kind !== want.kind || got.pos !== want.pos || got.last !== want.last) begin
					$display("%0t: expected kind %0d at (%0d,%0d) last %0d, actual kind %0d at (%0d,%0d) last %0d",
						$time, want.kind, want.pos.x, want.pos.y, want.last,
						got.kind, got.pos.x, got.pos.y, got.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_gestures();
		test_finger_limits();
		test_backpressure();
		test_random_gestures();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
design/pgr_pkg.sv
design/pgr_core.sv
design/pgr_res_fifo.sv
design/pointer_gesture_recognizer_top.sv
sim/pointer_gesture_recognizer_top_tb.sv
